// File: rtl/core/utx_pkg.sv
// shared types and constants for the uart byte and decimal transmitter
// no dependencies
`default_nettype none

package utx_pkg;

   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned FRAME_W    = 10;
   localparam int unsigned BCD_W      = 20;
   localparam int unsigned BITCNT_W   = 4;
   localparam int unsigned STEPCNT_W  = 4;
   localparam int unsigned DIGCNT_W   = 3;

   localparam logic [BITCNT_W-1:0]  FRAME_BITS    = 4'd10;
   localparam logic [STEPCNT_W-1:0] LAST_STEP     = 4'd15;
   localparam logic [DIGCNT_W-1:0]  DIGITS_SMALL  = 3'd3;
   localparam logic [DIGCNT_W-1:0]  DIGITS_LARGE  = 3'd5;
   localparam logic [VALUE_W-1:0]   SMALL_MAX     = 16'h00FF;
   localparam logic [7:0]           ASCII_ZERO    = 8'h30;

   localparam logic FUNC_BYTE   = 1'b0;
   localparam logic FUNC_NUMBER = 1'b1;

   typedef struct packed {
      logic                func;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic last_bit;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOAD,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic capture;
      logic dabble;
      logic load_frame;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic is_number;
      logic conv_done;
      logic out_free;
      logic bit_end;
      logic last_frame;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/core/utx_dpath.sv
// datapath: binary to bcd converter, frame shifter and result register
// depends on utx_pkg
`default_nettype none

module utx_dpath import utx_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire req_type  req_payload,
   input  wire cmd_type  cmd,
   output sts_type       sts,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   logic                  func_ff, func_in;
   logic [VALUE_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [STEPCNT_W-1:0]  step_ff, step_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic [BITCNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [DIGCNT_W-1:0]   digleft_ff, digleft_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [BCD_W-1:0]      bcd_adj;
   logic [3:0]            digit;
   logic [DIGCNT_W-1:0]   dig_idx;
   logic [7:0]            tx_byte;

   // add-3 correction on each bcd digit before the shift
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // most significant digit first
   assign dig_idx = DIGITS_LARGE - digleft_ff;

   always_comb begin
      case (dig_idx)
         3'd0:    digit = bcd_ff[19:16];
         3'd1:    digit = bcd_ff[15:12];
         3'd2:    digit = bcd_ff[11:8];
         3'd3:    digit = bcd_ff[7:4];
         3'd4:    digit = bcd_ff[3:0];
         default: digit = 4'd0;
      endcase
   end

   assign tx_byte = (func_ff == FUNC_NUMBER) ? (ASCII_ZERO + {4'd0, digit}) : bin_ff[7:0];

   always_comb begin
      func_in      = func_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      frame_in     = frame_ff;
      bitcnt_in    = bitcnt_ff;
      digleft_in   = digleft_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (cmd.capture) begin
         func_in = req_payload.func;
         bin_in  = req_payload.value;
         bcd_in  = '0;
         step_in = '0;
         digleft_in = (req_payload.value <= SMALL_MAX) ? DIGITS_SMALL : DIGITS_LARGE;
      end
      if (cmd.dabble) begin
         {bcd_in, bin_in} = {bcd_adj[BCD_W-2:0], bin_ff, 1'b0};
         step_in = step_ff + 1'b1;
      end
      if (cmd.load_frame) begin
         frame_in  = {1'b1, tx_byte, 1'b0};
         bitcnt_in = FRAME_BITS;
         if (func_ff == FUNC_NUMBER) begin
            digleft_in = digleft_ff - 1'b1;
         end
      end
      if (cmd.shift) begin
         rsp_in.line_level = frame_ff[0];
         rsp_in.last_bit   = sts.bit_end & sts.last_frame;
         rsp_valid_in      = 1'b1;
         frame_in  = {1'b1, frame_ff[FRAME_W-1:1]};
         bitcnt_in = bitcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         func_ff      <= FUNC_BYTE;
         step_ff      <= '0;
         frame_ff     <= '1;
         bitcnt_ff    <= '0;
         digleft_ff   <= '0;
         bcd_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         func_ff      <= func_in;
         step_ff      <= step_in;
         frame_ff     <= frame_in;
         bitcnt_ff    <= bitcnt_in;
         digleft_ff   <= digleft_in;
         bcd_ff       <= bcd_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.is_number  = (req_payload.func == FUNC_NUMBER);
      sts.conv_done  = (step_ff == LAST_STEP);
      sts.out_free   = ~rsp_valid_ff | ~rsp_stall;
      sts.bit_end    = (bitcnt_ff == 4'd1);
      sts.last_frame = (func_ff == FUNC_BYTE) || (digleft_ff == '0);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/utx_ctrl.sv
// controller state machine: sequences capture, conversion, frame load and shift
// depends on utx_pkg
`default_nettype none

module utx_ctrl import utx_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = sts.is_number ? ST_CONVERT : ST_LOAD;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_frame = 1'b1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // one bit per cycle while the result register can take it
            if (sts.out_free) begin
               cmd.shift = 1'b1;
               if (sts.bit_end) begin
                  state_in = sts.last_frame ? ST_IDLE : ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/uart_tx_byte_and_decimal.sv
// uart 8n1 transmitter, byte or decimal ascii; one item in flight at a time
// a byte item is one frame; a number item first runs the 16-step shift-add-3 converter,
// then sends three digit frames (<=255) or five, each a frame load and ten bit shifts;
// the bit shifts wait while rsp_stall is high and a bit is still held in the result
// register
// reset: synchronous, returns to idle with the frame register held at ones and no bit valid
`default_nettype none

module uart_tx_byte_and_decimal import utx_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   utx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   utx_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a second item without a busy cycle");

   a_last_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_bit |-> rsp_payload.line_level)
      else $error("last bit of a run is not a stop bit");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_stall)
      else $error("not ready after reset");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for uart_tx_byte_and_decimal: byte frames and decimal ascii sends,
// checked bit by bit against a local frame predictor; depends on utx_pkg and the rtl
module tb;
   import utx_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 440;
   localparam int unsigned QUIET_TAIL   = 40;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned DRAIN_CYCLES = 100;

   typedef struct {
      req_type item;
      bit      wait_drain;
   } send_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   send_slot_type send_queue[$];
   rsp_type     line_expect[$];
   logic        req_fire = 1'b0;
   int unsigned accepted = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   uart_tx_byte_and_decimal uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // start bit, eight data bits lsb first, stop bit
   function automatic void push_frame(logic [7:0] ch, logic closing);
      logic [9:0] frame;
      rsp_type    bit_out;
      frame = {1'b1, ch, 1'b0};
      for (int b = 0; b < 10; b++) begin
         bit_out.line_level = frame[b];
         bit_out.last_bit   = closing && (b == 9);
         line_expect.push_back(bit_out);
      end
   endfunction

   function automatic void predict_line_bits(req_type r);
      int unsigned v;
      int          ndig;
      logic [3:0]  dig[5];
      if (r.func == FUNC_BYTE) begin
         push_frame(r.value[7:0], 1'b1);
      end else begin
         v = {16'd0, r.value};
         for (int i = 0; i < 5; i++) begin
            dig[i] = 4'(v % 10);
            v = v / 10;
         end
         ndig = (r.value <= SMALL_MAX) ? int'(DIGITS_SMALL) : int'(DIGITS_LARGE);
         for (int k = ndig - 1; k >= 0; k--)
            push_frame(ASCII_ZERO + {4'b0000, dig[k]}, k == 0);
      end
   endfunction

   function automatic void add_send(logic func, logic [VALUE_W-1:0] value, bit wait_drain);
      send_slot_type s;
      s.item.func  = func;
      s.item.value = value;
      s.wait_drain = wait_drain;
      send_queue.push_back(s);
   endfunction

   // sampling side: check bits that leave, predict for items that enter
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (line_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected bit level=%b last=%b",
                                         rsp_payload.line_level, rsp_payload.last_bit));
            end else begin
               if (rsp_payload.line_level !== line_expect[0].line_level)
                  report_mismatch($sformatf("line_level got %b want %b",
                                            rsp_payload.line_level,
                                            line_expect[0].line_level));
               if (rsp_payload.last_bit !== line_expect[0].last_bit)
                  report_mismatch($sformatf("last_bit got %b want %b",
                                            rsp_payload.last_bit, line_expect[0].last_bit));
               void'(line_expect.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            predict_line_bits(req_payload);
            accepted <= accepted + 1;
         end
      end
   end

   // sender: new item only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (send_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (send_queue[0].wait_drain && line_expect.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            req_payload <= send_queue[0].item;
            req_valid   <= 1'b1;
            void'(send_queue.pop_front());
            if (send_queue.size() > QUIET_TAIL && (send_queue.size() / 50) % 3 != 0
                && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 18);
         end
      end
   end

   // receiver: one long hold to back the block up, plus random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted >= 60) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (send_queue.size() > QUIET_TAIL && (cycle_count / 700) % 3 != 0
                   && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      int unsigned kind;
      logic [VALUE_W-1:0] corner[8];

      corner = '{16'd0, 16'd255, 16'd256, 16'd65535, 16'd9999, 16'd10000,
                 16'd99, 16'd100};

      // directed: byte extremes, upper byte ignored, digit count boundaries
      add_send(FUNC_BYTE,   16'h0000, 1'b0);
      add_send(FUNC_BYTE,   16'h00FF, 1'b0);
      add_send(FUNC_BYTE,   16'hFF00, 1'b0);
      add_send(FUNC_BYTE,   16'h0055, 1'b0);
      add_send(FUNC_BYTE,   16'h00AA, 1'b0);
      add_send(FUNC_BYTE,   16'hFFFF, 1'b0);
      add_send(FUNC_BYTE,   16'h8001, 1'b0);
      add_send(FUNC_NUMBER, 16'd0,     1'b0);
      add_send(FUNC_NUMBER, 16'd7,     1'b0);
      add_send(FUNC_NUMBER, 16'd99,    1'b0);
      add_send(FUNC_NUMBER, 16'd100,   1'b0);
      add_send(FUNC_NUMBER, 16'd255,   1'b0);
      add_send(FUNC_NUMBER, 16'd256,   1'b0);
      add_send(FUNC_NUMBER, 16'd999,   1'b0);
      add_send(FUNC_NUMBER, 16'd1000,  1'b0);
      add_send(FUNC_NUMBER, 16'd9999,  1'b0);
      add_send(FUNC_NUMBER, 16'd10000, 1'b0);
      add_send(FUNC_NUMBER, 16'd12345, 1'b0);
      add_send(FUNC_NUMBER, 16'd32768, 1'b0);
      add_send(FUNC_NUMBER, 16'h5555,  1'b0);
      add_send(FUNC_NUMBER, 16'hAAAA,  1'b0);
      add_send(FUNC_NUMBER, 16'd65535, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 9);
         // now and then the sender waits for the line to go quiet first
         if (kind <= 3)
            add_send(FUNC_BYTE, 16'($urandom_range(0, 65535)), (i % 97) == 0);
         else if (kind <= 6)
            add_send(FUNC_NUMBER, 16'($urandom_range(0, 255)), (i % 97) == 0);
         else if (kind <= 8)
            add_send(FUNC_NUMBER, 16'($urandom_range(256, 65535)), (i % 97) == 0);
         else
            add_send(1'($urandom_range(0, 1)), corner[$urandom_range(0, 7)],
                     (i % 97) == 0);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || req_valid) @(posedge clock);
      while (line_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (line_expect.size() != 0)
         report_mismatch($sformatf("%0d bits never sent", line_expect.size()));

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
